[rtl/core/iayu_pkg.sv]
// Shared types and constants for the IMU angle frame parser with yaw unwrap.
// No dependencies; imported by every other file of the block.
package iayu_pkg;

  // Frame layout
  localparam int          FRAME_BYTES  = 11;
  localparam logic [7:0]  HEADER_BYTE  = 8'h55;
  localparam logic [7:0]  TYPE_BYTE    = 8'h53;
  localparam logic [3:0]  POS_AFTER_HDR  = 4'd1;
  localparam logic [3:0]  POS_FIRST_DATA = 4'd2;
  localparam logic [3:0]  POS_YAW_LO   = 4'd6;
  localparam logic [3:0]  POS_YAW_HI   = 4'd7;
  localparam logic [3:0]  POS_CHECKSUM = 4'(FRAME_BYTES - 1);

  // Angle arithmetic, raw units of 180/32768 degree
  localparam logic signed [17:0] HALF_TURN = 18'sd32768;
  localparam logic signed [17:0] FULL_TURN = 18'sd65536;

  typedef logic [3:0]         pos_t;
  typedef logic signed [15:0] yaw_t;
  typedef logic signed [31:0] total_t;

  // Parser phase; code 3 is unused and falls back to header search
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

endpackage

[rtl/core/iayu_byte_if.sv]
// Stream interface carrying received serial bytes into the parser.
// Depends on iayu_pkg.
interface iayu_byte_if
  import iayu_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/iayu_yaw_if.sv]
// Stream interface carrying one yaw result per valid frame.
// Depends on iayu_pkg.
interface iayu_yaw_if
  import iayu_pkg::*;
();
  logic   valid;
  logic   ready;
  yaw_t   yaw_current;
  total_t yaw_total;
  logic   first_frame;

  modport source (output valid, output yaw_current, output yaw_total, output first_frame,
                  input ready);
  modport sink   (input valid, input yaw_current, input yaw_total, input first_frame,
                  output ready);
endinterface

[rtl/core/imu_angle_frame_yaw_unwrap_core.sv]
// A result is valid the cycle after the checksum byte transfer.
// Throughput: one byte per cycle, set by the parser and unwrap adder, unless input is held back.
// The result register only holds input back when a checksum byte would arrive while an
// earlier result is still waiting.
// Reset (rst, synchronous): parser to header search, no previous yaw, total cleared.
// Depends on iayu_pkg, iayu_byte_if, iayu_yaw_if and iayu_unwrap.
module imu_angle_frame_yaw_unwrap_core
  import iayu_pkg::*;
(
  input logic        clk,
  input logic        rst,
  iayu_byte_if.sink   rx_ch,
  iayu_yaw_if.source  yaw_ch
);

  phase_t phase, phase_next;
  pos_t   pos, pos_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] yaw_lo, yaw_lo_next;
  logic [7:0] yaw_hi, yaw_hi_next;
  yaw_t   previous_yaw;
  logic   have_previous;
  total_t yaw_accumulator;
  total_t unwrap_total;

  logic   out_valid;
  yaw_t   out_yaw;
  total_t out_total;
  logic   out_first;

  logic   in_xfer;
  logic   at_checksum;
  logic   emit;
  yaw_t   frame_yaw;

  assign at_checksum = (phase == PH_DATA) && (pos >= POS_CHECKSUM);
  // Hold input only if a result is pending and this byte could make another
  assign rx_ch.ready = !(out_valid && !yaw_ch.ready && at_checksum);
  assign in_xfer     = rx_ch.valid && rx_ch.ready;
  assign frame_yaw   = {yaw_hi, yaw_lo};

  iayu_unwrap u_unwrap (
    .cur   (frame_yaw),
    .prev  (previous_yaw),
    .acc   (yaw_accumulator),
    .total (unwrap_total)
  );

  // Parser next state
  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    running_sum_next = running_sum;
    yaw_lo_next      = yaw_lo;
    yaw_hi_next      = yaw_hi;
    emit             = 1'b0;
    if (in_xfer) begin
      case (phase)
        PH_HEADER: begin
          if (rx_ch.rx_byte == HEADER_BYTE) begin
            running_sum_next = rx_ch.rx_byte;
            pos_next         = POS_AFTER_HDR;
            phase_next       = PH_TYPE;
          end else begin
            running_sum_next = '0;
            pos_next         = '0;
          end
        end
        PH_TYPE: begin
          if (rx_ch.rx_byte == TYPE_BYTE) begin
            running_sum_next = running_sum + rx_ch.rx_byte;
            pos_next         = POS_FIRST_DATA;
            phase_next       = PH_DATA;
          end else begin
            running_sum_next = '0;
            pos_next         = '0;
            phase_next       = PH_HEADER;
          end
        end
        PH_DATA: begin
          if (!at_checksum) begin
            if (pos == POS_YAW_LO) begin
              yaw_lo_next = rx_ch.rx_byte;
            end
            if (pos == POS_YAW_HI) begin
              yaw_hi_next = rx_ch.rx_byte;
            end
            running_sum_next = running_sum + rx_ch.rx_byte;
            pos_next         = pos + 4'd1;
          end else begin
            emit             = (running_sum == rx_ch.rx_byte);
            running_sum_next = '0;
            pos_next         = '0;
            phase_next       = PH_HEADER;
          end
        end
        default: begin
          running_sum_next = '0;
          pos_next         = '0;
          phase_next       = PH_HEADER;
        end
      endcase
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      pos         <= '0;
      running_sum <= '0;
      yaw_lo      <= '0;
      yaw_hi      <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      running_sum <= running_sum_next;
      yaw_lo      <= yaw_lo_next;
      yaw_hi      <= yaw_hi_next;
    end
  end

  // Yaw tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_yaw    <= '0;
      have_previous   <= 1'b0;
      yaw_accumulator <= '0;
    end else if (emit) begin
      previous_yaw  <= frame_yaw;
      have_previous <= 1'b1;
      if (have_previous) begin
        yaw_accumulator <= unwrap_total;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (yaw_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_yaw   <= frame_yaw;
      out_total <= have_previous ? unwrap_total : yaw_accumulator;
      out_first <= !have_previous;
    end
  end

  assign yaw_ch.valid       = out_valid;
  assign yaw_ch.yaw_current = out_yaw;
  assign yaw_ch.yaw_total   = out_total;
  assign yaw_ch.first_frame = out_first;

endmodule

[rtl/core/iayu_unwrap.sv]
// Yaw unwrap step: wraps the frame-to-frame difference into a half turn and
// adds it to the running total with signed 32-bit saturation. Depends on iayu_pkg.
module iayu_unwrap
  import iayu_pkg::*;
(
  input  yaw_t   cur,
  input  yaw_t   prev,
  input  total_t acc,
  output total_t total
);

  logic signed [17:0] diff;
  logic signed [17:0] diff_wrapped;
  logic signed [33:0] sum;

  // Wrap only differences strictly beyond a half turn
  always_comb begin
    diff = 18'(cur) - 18'(prev);
    if (diff > HALF_TURN) begin
      diff_wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      diff_wrapped = diff + FULL_TURN;
    end else begin
      diff_wrapped = diff;
    end
  end

  // Saturating accumulate
  always_comb begin
    sum = 34'(acc) + 34'(diff_wrapped);
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      total = sum[31:0];
    end else if (sum[33]) begin
      total = {1'b1, {31{1'b0}}};
    end else begin
      total = {1'b0, {31{1'b1}}};
    end
  end

endmodule

[rtl/core/iayu_checker.sv]
// Port-level checks for the yaw unwrap core, attached by bind below.
// Depends on iayu_pkg and the top level's channel interfaces.
module iayu_checker
  import iayu_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   rx_valid,
  input logic   rx_ready,
  input logic   yaw_valid,
  input logic   yaw_ready,
  input yaw_t   yaw_current,
  input total_t yaw_total,
  input logic   first_frame
);

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    yaw_valid && !yaw_ready |=> yaw_valid && $stable(yaw_current) && $stable(yaw_total)
      && $stable(first_frame))
    else $error("result changed while stalled");

  // Input is only held back while a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> yaw_valid && !yaw_ready)
    else $error("input stalled without a pending result");

  // The seeding frame comes before any accumulation
  a_first: assert property (@(posedge clk) disable iff (rst)
    yaw_valid && first_frame |-> yaw_total == '0)
    else $error("first frame carries a nonzero total");

  // A new result right after a result transfer needs a byte transfer on that same edge
  a_gap: assert property (@(posedge clk) disable iff (rst)
    yaw_valid && yaw_ready |=> !yaw_valid || $past(rx_valid && rx_ready))
    else $error("result directly after a result transfer");

endmodule

bind imu_angle_frame_yaw_unwrap_core iayu_checker u_iayu_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_valid    (rx_ch.valid),
  .rx_ready    (rx_ch.ready),
  .yaw_valid   (yaw_ch.valid),
  .yaw_ready   (yaw_ch.ready),
  .yaw_current (yaw_ch.yaw_current),
  .yaw_total   (yaw_ch.yaw_total),
  .first_frame (yaw_ch.first_frame)
);
